// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every rising edge of clk outside reset.
`define PBTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every rising edge of clk, reset included.
`define PBTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBTS_ASSERT(label, prop, msg)
`define PBTS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/core/pbts_pkg.sv =====
// Shared constants and types of the priority bitmap scheduler.
package pbts_pkg;

  localparam int TASK_COUNT  = 64;
  localparam int DELAY_WIDTH = 16;

  localparam int PRIO_W     = $clog2(TASK_COUNT);
  localparam int IDLE_PRIO  = TASK_COUNT - 1;
  localparam int LAST_SWEEP = IDLE_PRIO - 1;

  localparam int GROUP_SIZE  = 8;
  localparam int GIDX_W      = $clog2(GROUP_SIZE);
  localparam int GROUP_COUNT = (TASK_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GROUP_W     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int PAD_W       = GROUP_COUNT * GROUP_SIZE;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_DELAY  = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] prio;
  } find_res_t;

endpackage

// ===== rtl/core/pbts_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/pbts_find.sv =====
// Two-level registered search for the lowest-numbered ready priority.
module pbts_find (
  input  logic                           clk,
  input  logic [pbts_pkg::TASK_COUNT-1:0] ready_bits,
  output pbts_pkg::find_res_t            res
);

  import pbts_pkg::*;

  logic [PAD_W-1:0]       padded;
  logic [GROUP_COUNT-1:0] grp_any;
  logic [GIDX_W-1:0]      grp_idx [GROUP_COUNT];

  function automatic logic [GIDX_W-1:0] lowest_set(input logic [GROUP_SIZE-1:0] v);
    logic [GIDX_W-1:0] idx;
    idx = '0;
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (v[i]) idx = GIDX_W'(i);
    end
    return idx;
  endfunction

  // Pad with zeros so that a short last group never reports a phantom hit.
  assign padded = PAD_W'(ready_bits);

  always_ff @(posedge clk) begin
    for (int g = 0; g < GROUP_COUNT; g++) begin
      grp_any[g] <= |padded[g*GROUP_SIZE +: GROUP_SIZE];
      grp_idx[g] <= lowest_set(padded[g*GROUP_SIZE +: GROUP_SIZE]);
    end
  end

  always_comb begin
    res.found = |grp_any;
    res.prio  = '0;
    for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
      if (grp_any[g]) res.prio = PRIO_W'({GROUP_W'(g), grp_idx[g]});
    end
  end

endmodule

// ===== rtl/core/priority_bitmap_task_scheduler.sv =====
// Top level of the priority bitmap task scheduler.
//
// Input channel (in_valid / in_stall) carries one event word: mode, task_prio
// and delay_ticks. Output channel (out_valid / out_stall) returns one result
// word per event: the lowest-numbered ready priority, a none-ready flag and
// the tick count after the event.
// Events are handled one at a time. Create, delay and no-op pass from
// acceptance through the find and done states to the result; a tick first
// passes the sweep, which reads, decrements and writes back one delay
// counter of the counter RAM per cycle.
// The ready search is a registered two-level tree over groups of eight.
// A result word is held in the output register until taken; the next event
// is accepted meanwhile, and its result waits until the register is free.
// in_stall is high whenever an event is in progress.
// Reset clears the ready, delayed and exists bitmaps and the tick count; the
// counter RAM is not cleared, as a counter is always loaded before its value is used.
module priority_bitmap_task_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [5:0]  task_prio,
  input  logic [15:0] delay_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  high_ready_prio,
  output logic        none_ready,
  output logic [31:0] tick_count
);

  import pbts_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_FIND, S_DONE} state_t;

  state_t                 state;
  logic [TASK_COUNT-1:0]  ready_bits;
  logic [TASK_COUNT-1:0]  delayed_bits;
  logic [TASK_COUNT-1:0]  exists_bits;
  logic [31:0]            tick_counter;
  logic [PRIO_W-1:0]      swp_addr;
  logic                   swp_issue;
  logic                   wb_valid;
  logic [PRIO_W-1:0]      wb_addr;

  logic                   in_acc;
  logic [PRIO_W-1:0]      idx;
  logic                   in_range;
  logic [DELAY_WIDTH-1:0] ticks;
  logic                   wb_active;
  logic [DELAY_WIDTH-1:0] dec;

  logic                   ram_we;
  logic [PRIO_W-1:0]      ram_wr_addr;
  logic [DELAY_WIDTH-1:0] ram_wr_data;
  logic                   ram_re;
  logic [DELAY_WIDTH-1:0] ram_rd_data;
  find_res_t              find_res;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign idx       = PRIO_W'(task_prio);
  assign in_range  = int'(task_prio) < TASK_COUNT;
  assign ticks     = DELAY_WIDTH'(delay_ticks);
  assign wb_active = wb_valid && exists_bits[wb_addr] && delayed_bits[wb_addr];
  assign dec       = DELAY_WIDTH'(ram_rd_data - DELAY_WIDTH'(1));

  assign ram_re = (state == S_SWEEP) && swp_issue;

  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = idx;
    ram_wr_data = ticks;
    if (in_acc && in_range) begin
      case (mode_t'(mode))
        MODE_CREATE: begin
          ram_we      = 1'b1;
          ram_wr_data = '0;
        end
        MODE_DELAY: ram_we = exists_bits[idx];
        default: ;
      endcase
    end
    // Write back the decremented counter in the cycle after its read.
    if (state == S_SWEEP && wb_active) begin
      ram_we      = 1'b1;
      ram_wr_addr = wb_addr;
      ram_wr_data = dec;
    end
  end

  pbts_ram #(
    .WIDTH(DELAY_WIDTH),
    .DEPTH(TASK_COUNT)
  ) u_cnt_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .re     (ram_re),
    .rd_addr(swp_addr),
    .rd_data(ram_rd_data)
  );

  pbts_find u_find (
    .clk       (clk),
    .ready_bits(ready_bits),
    .res       (find_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ready_bits   <= '0;
      delayed_bits <= '0;
      exists_bits  <= '0;
      tick_counter <= '0;
      swp_issue    <= 1'b0;
      wb_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (mode_t'(mode) == MODE_TICK) ? S_SWEEP : S_FIND;
            case (mode_t'(mode))
              MODE_CREATE: begin
                if (in_range) begin
                  exists_bits[idx]  <= 1'b1;
                  ready_bits[idx]   <= 1'b1;
                  delayed_bits[idx] <= 1'b0;
                end
              end
              MODE_DELAY: begin
                if (in_range && exists_bits[idx]) begin
                  ready_bits[idx]   <= 1'b0;
                  delayed_bits[idx] <= 1'b1;
                end
              end
              MODE_TICK: begin
                tick_counter <= tick_counter + 32'd1;
                swp_addr     <= '0;
                swp_issue    <= 1'b1;
                wb_valid     <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_SWEEP: begin
          wb_valid <= swp_issue;
          wb_addr  <= swp_addr;
          // Advance the read pointer; the idle priority is never swept.
          if (swp_issue) begin
            if (swp_addr == PRIO_W'(LAST_SWEEP)) begin
              swp_issue <= 1'b0;
            end else begin
              swp_addr <= PRIO_W'(swp_addr + 1'b1);
            end
          end else begin
            state <= S_FIND;
          end
          if (wb_active && dec == '0) begin
            delayed_bits[wb_addr] <= 1'b0;
            ready_bits[wb_addr]   <= 1'b1;
          end
        end
        S_FIND: state <= S_DONE;
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            high_ready_prio <= 6'(find_res.prio);
            none_ready      <= !find_res.found;
            tick_count      <= tick_counter;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PBTS_ASSERT(a_ram_no_clash, (ram_we && ram_re) |-> (ram_wr_addr != swp_addr), "RAM read and write hit one entry")
  `PBTS_ASSERT(a_out_from_done, $rose(out_valid) |-> $past(state == S_DONE), "result word raised outside done")
  `PBTS_ASSERT(a_none_zero, (out_valid && none_ready) |-> (high_ready_prio == 6'd0), "none ready with non-zero priority")
  `PBTS_ASSERT(a_tick_only_on_tick, (!$past(rst) && tick_counter != $past(tick_counter)) |-> $past(in_acc && mode == MODE_TICK), "tick count moved without a tick")
  `PBTS_ASSERT(a_idle_ready_by_create, (!$past(rst) && ready_bits[IDLE_PRIO] && !$past(ready_bits[IDLE_PRIO])) |-> $past(in_acc && mode == MODE_CREATE), "idle priority woke without create")

endmodule
